/* src/stb_pkg.sv */
// Shared types and constants for the software timer bank.
// No dependencies; imported by every module of the block.
`default_nettype none

package stb_pkg;

    localparam int CNT_W          = 31;
    localparam int REQ_W          = 3;
    localparam int IDX_W          = 3;
    localparam int MASK_W         = 8;
    localparam int NUM_TIMERS_DEF = 8;
    // Timers reachable through the 3-bit index field.
    localparam int ADDR_SPAN      = 1 << IDX_W;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_SET   = 3'd3,
        REQ_READ  = 3'd4
    } t_req_type;

    // Per-timer update controls from the request decode.
    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
        logic set;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* src/stb_timer_cell.sv */
// One timer: saturating up/down count register and running flag.
// Depends on stb_pkg.
`default_nettype none

module stb_timer_cell
    import stb_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  wire              i_count_up,
    input  wire [CNT_W-1:0]  i_set_value,
    output logic [CNT_W-1:0] o_n_count,
    output logic             o_n_running
);

    logic [CNT_W-1:0] r_count;
    logic             r_running;
    logic [CNT_W-1:0] n_count;
    logic             n_running;

    always_comb begin
        n_count   = r_count;
        n_running = r_running;
        if (i_ctrl.tick && r_running) begin
            // hold at the rails
            if (i_count_up) begin
                if (r_count != CNT_MAX) begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (r_count != '0) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
        if (i_ctrl.set) begin
            n_count = i_set_value;
        end
        if (i_ctrl.start) begin
            n_running = 1'b1;
        end
        if (i_ctrl.stop) begin
            n_running = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_running <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_running <= n_running;
        end
    end

    assign o_n_count   = n_count;
    assign o_n_running = n_running;

endmodule

`default_nettype wire

/* src/stb_result_sel.sv */
// Result select and output register: picks the addressed timer's new state.
// Depends on stb_pkg.
`default_nettype none

module stb_result_sel
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_done,
    input  wire              i_idx_ok,
    input  wire [IDX_W-1:0]  i_index,
    input  wire [CNT_W-1:0]  i_n_count   [NUM_TIMERS],
    input  wire              i_n_running [NUM_TIMERS],
    output logic             o_done,
    output logic [CNT_W-1:0] o_count_value,
    output logic             o_is_running
);

    localparam int SEL_N = (NUM_TIMERS < ADDR_SPAN) ? NUM_TIMERS : ADDR_SPAN;

    logic             r_done;
    logic [CNT_W-1:0] r_count;
    logic             r_running;
    logic [CNT_W-1:0] n_count;
    logic             n_running;

    always_comb begin
        n_count   = '0;
        n_running = 1'b0;
        for (int i = 0; i < SEL_N; i++) begin
            if (i_idx_ok && (i_index == IDX_W'(i))) begin
                n_count   = i_n_count[i];
                n_running = i_n_running[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_running <= n_running;
    end

    assign o_done        = r_done;
    assign o_count_value = r_count;
    assign o_is_running  = r_running;

endmodule

`default_nettype wire

/* src/software_timer_bank.sv */
// Top level of the software timer bank: request register, timer cells,
// result select. Depends on stb_pkg, stb_timer_cell, stb_result_sel.
//
//   channel   handshake          payload
//   --------  -----------------  ---------------------------------------------
//   request   start / busy       i_req_type, i_timer_index, i_set_value
//   result    o_done (strobe)    o_count_value, o_is_running
//   config    i_cfg_we           i_cfg_wdata (count_up_mask)
//
// A request is taken at any edge with start high and busy low; busy is low
// in every cycle after reset, so one request per cycle is sustained.
// A request passes the request register, then one pass through the
// timer update logic into the timer registers and the result register.
// o_done is high for exactly one cycle per request; the receiver cannot
// stall, so nothing holds the pipeline. Reset (synchronous, active low)
// clears all counts, running flags and the mask, and holds busy high.
`default_nettype none

module software_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire [REQ_W-1:0]   i_req_type,
    input  wire [IDX_W-1:0]   i_timer_index,
    input  wire [CNT_W-1:0]   i_set_value,
    input  wire               i_cfg_we,
    input  wire [MASK_W-1:0]  i_cfg_wdata,
    output logic              o_done,
    output logic [CNT_W-1:0]  o_count_value,
    output logic              o_is_running
);

    // Wide enough to hold NUM_TIMERS itself for the range check.
    localparam int NT_W = $clog2(NUM_TIMERS + 1) + 1;

    logic               r_busy;
    logic [MASK_W-1:0]  r_mask;

    // request register
    logic               r_req_vld;
    logic [REQ_W-1:0]   r_req_type;
    logic [IDX_W-1:0]   r_index;
    logic [CNT_W-1:0]   r_set_value;

    logic               accept;
    logic               idx_ok;
    logic               is_tick;

    logic [CNT_W-1:0]   cell_n_count   [NUM_TIMERS];
    logic               cell_n_running [NUM_TIMERS];

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // Hold busy through reset so nothing is taken while state clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type  <= i_req_type;
            r_index     <= i_timer_index;
            r_set_value <= i_set_value;
        end
    end

    // Index past the bank: addresses nothing, reports zero. Ticks still run.
    assign idx_ok  = (NT_W'(r_index) < NT_W'(NUM_TIMERS));
    assign is_tick = r_req_vld && (r_req_type == REQ_TICK);

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        t_cell_ctrl ctrl;
        logic       hit;
        logic       up;

        assign hit = r_req_vld && (NT_W'(r_index) == NT_W'(g));

        // Timers beyond the mask width always count down.
        if (g < MASK_W) begin : g_up
            assign up = r_mask[g];
        end else begin : g_down
            assign up = 1'b0;
        end

        // Unused request codes fall through as reads.
        always_comb begin
            ctrl.tick  = is_tick;
            ctrl.start = hit && (r_req_type == REQ_START);
            ctrl.stop  = hit && (r_req_type == REQ_STOP);
            ctrl.set   = hit && (r_req_type == REQ_SET);
        end

        stb_timer_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_count_up  (up),
            .i_set_value (r_set_value),
            .o_n_count   (cell_n_count[g]),
            .o_n_running (cell_n_running[g])
        );
    end

    // Report the addressed timer as it stands after this request.
    stb_result_sel #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_sel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_done        (r_req_vld),
        .i_idx_ok      (idx_ok),
        .i_index       (r_index),
        .i_n_count     (cell_n_count),
        .i_n_running   (cell_n_running),
        .o_done        (o_done),
        .o_count_value (o_count_value),
        .o_is_running  (o_is_running)
    );

endmodule

`default_nettype wire

/* src/stb_checker.sv */
// Port-level checks for the software timer bank, bound to the top level.
// Depends on stb_pkg and software_timer_bank.
`default_nettype none

module stb_checker
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               start,
    input wire               busy,
    input wire [REQ_W-1:0]   i_req_type,
    input wire [IDX_W-1:0]   i_timer_index,
    input wire [CNT_W-1:0]   i_set_value,
    input wire               i_cfg_we,
    input wire [MASK_W-1:0]  i_cfg_wdata,
    input wire               o_done,
    input wire [CNT_W-1:0]   o_count_value,
    input wire               o_is_running
);

    localparam int NT_W = $clog2(NUM_TIMERS + 1) + 1;

    logic acc;
    logic in_bank;

    assign acc     = start && !busy;
    assign in_bank = (NT_W'(i_timer_index) < NT_W'(NUM_TIMERS));

    // one result per request
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##2 o_done)
        else $error("request without result");

    a_done_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(acc, 2))
        else $error("result without request");

    a_out_of_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !in_bank) |-> ##2 (o_count_value == '0 && !o_is_running))
        else $error("out-of-bank request reported nonzero");

    a_set_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && in_bank && i_req_type == REQ_SET)
            |-> ##2 (o_count_value == $past(i_set_value, 2)))
        else $error("set request reported wrong count");

    a_stop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req_type == REQ_STOP) |-> ##2 !o_is_running)
        else $error("stopped timer reported running");

endmodule

bind software_timer_bank stb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_stb_checker (.*);

`default_nettype wire

/* dv/stb_timer_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the software timer bank: watches requests, mask writes and
// reports, predicts each report from its own timer state and compares.
// Depends on stb_pkg.
module stb_timer_checker
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire              i_busy,
    input  wire [REQ_W-1:0]  i_req_type,
    input  wire [IDX_W-1:0]  i_timer_index,
    input  wire [CNT_W-1:0]  i_set_value,
    input  wire              i_cfg_we,
    input  wire [MASK_W-1:0] i_cfg_wdata,
    input  wire              i_done,
    input  wire [CNT_W-1:0]  i_count_value,
    input  wire              i_is_running,
    output int               o_pending,
    output int               o_fail_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             running;
    } t_timer_report;

    logic [CNT_W-1:0]  model_count [NUM_TIMERS];
    logic              model_running [NUM_TIMERS];
    logic [MASK_W-1:0] model_up_mask;
    t_timer_report     expected_reports [$];
    t_timer_report     want;
    int                mismatch_count;

    initial begin
        mismatch_count = 0;
    end

    // Apply one request to the timer state and return what the block reports.
    function automatic t_timer_report step_timer_bank(input logic [REQ_W-1:0] kind,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [CNT_W-1:0] val);
        t_timer_report rep;
        bit            in_bank;
        in_bank = int'(idx) < NUM_TIMERS;
        if (kind == REQ_TICK) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                if (model_running[t]) begin
                    // timers past the mask width have no direction bit: down
                    if (t < MASK_W && model_up_mask[t]) begin
                        if (model_count[t] != CNT_MAX)
                            model_count[t] = model_count[t] + 1'b1;
                    end else begin
                        if (model_count[t] != '0)
                            model_count[t] = model_count[t] - 1'b1;
                    end
                end
            end
        end else if (in_bank) begin
            case (kind)
                REQ_START: model_running[idx] = 1'b1;
                REQ_STOP:  model_running[idx] = 1'b0;
                REQ_SET:   model_count[idx]   = val;
                default: ;
            endcase
        end
        if (in_bank)
            rep = '{count: model_count[idx], running: model_running[idx]};
        else
            rep = '0;
        return rep;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                model_count[t]   = '0;
                model_running[t] = 1'b0;
            end
            model_up_mask = '0;
            expected_reports.delete();
        end else begin
            // check first: a report here belongs to a request taken earlier
            if (i_done) begin
                if (expected_reports.size() == 0) begin
                    note_failure($sformatf(
                        "report with no request outstanding: count %0d running %0b",
                        i_count_value, i_is_running));
                end else begin
                    want = expected_reports.pop_front();
                    if (i_count_value !== want.count)
                        note_failure($sformatf("count mismatch: expected %0d, got %0d",
                                               want.count, i_count_value));
                    if (i_is_running !== want.running)
                        note_failure($sformatf("running flag mismatch: expected %0b, got %0b",
                                               want.running, i_is_running));
                end
            end
            if (i_cfg_we)
                model_up_mask = i_cfg_wdata;
            if (i_start && !i_busy)
                expected_reports.push_back(step_timer_bank(i_req_type, i_timer_index,
                                                           i_set_value));
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= mismatch_count;
    end

endmodule

/* dv/tb_software_timer_bank.sv */
`timescale 1ns / 1ps
// Testbench top for the software timer bank: clock, reset, request and
// direction-mask stimulus, verdict. Depends on stb_pkg, software_timer_bank
// and stb_timer_checker.
module tb_software_timer_bank;
    import stb_pkg::*;

    localparam int RESET_CYCLES   = 12;
    // Idle margin after the last report before a mask write.
    localparam int DRAIN_CYCLES   = 4;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_REQUESTS = 150;
    // Request codes past the last defined one behave like a read.
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = REQ_W'(REQ_READ + 1);
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = {REQ_W{1'b1}};

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_start       = 1'b0;
    logic [REQ_W-1:0]  i_req_type    = REQ_TICK;
    logic [IDX_W-1:0]  i_timer_index = '0;
    logic [CNT_W-1:0]  i_set_value   = '0;
    logic              i_cfg_we      = 1'b0;
    logic [MASK_W-1:0] i_cfg_wdata   = '0;
    logic              busy;
    logic              o_done;
    logic [CNT_W-1:0]  o_count_value;
    logic              o_is_running;
    int                pending;
    int                fail_count;
    bit                gaps_on = 1'b1;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    software_timer_bank i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (i_start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_timer_index (i_timer_index),
        .i_set_value   (i_set_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_count_value (o_count_value),
        .o_is_running  (o_is_running)
    );

    stb_timer_checker u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (busy),
        .i_req_type    (i_req_type),
        .i_timer_index (i_timer_index),
        .i_set_value   (i_set_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_done        (o_done),
        .i_count_value (o_count_value),
        .i_is_running  (o_is_running),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Present one request and hold it until the block takes it. Afterwards,
    // sometimes drop start for a short burst so idle cycles land at every
    // point of the pipeline; otherwise leave start high for back-to-back flow.
    task automatic issue_request(input logic [REQ_W-1:0] kind,
                                 input logic [IDX_W-1:0] idx,
                                 input logic [CNT_W-1:0] val);
        i_start       <= 1'b1;
        i_req_type    <= kind;
        i_timer_index <= idx;
        i_set_value   <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every report has come back, then let the
    // pipeline settle. The first edge makes sure the pending count seen here
    // already covers the last request taken.
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
    endtask

    // Write the direction mask only with the block idle.
    task automatic write_up_mask(input logic [MASK_W-1:0] mask);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Bias counts toward both ends so ticks reach the saturation points often.
    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 3))
            0:       return CNT_W'($urandom_range(0, 3));
            1:       return CNT_MAX - CNT_W'($urandom_range(0, 3));
            default: return CNT_W'($urandom());
        endcase
    endfunction

    // A mix of ticks, control and reads of random timers; set value is random on
    // every request so its bits toggle even where it is ignored.
    task automatic issue_random_request();
        int unsigned      pick;
        logic [REQ_W-1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            kind = REQ_TICK;
        else if (pick < 50)
            kind = REQ_START;
        else if (pick < 60)
            kind = REQ_STOP;
        else if (pick < 75)
            kind = REQ_SET;
        else if (pick < 90)
            kind = REQ_READ;
        else
            kind = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        issue_request(kind, IDX_W'($urandom_range(0, ADDR_SPAN - 1)), pick_count());
    endtask

    // Hard stop: end the run if the stimulus or the drain hangs.
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_software_timer_bank: FAIL");
        $finish;
    end

    initial begin
        logic [MASK_W-1:0] phase_mask;

        // Hold reset, then release it; busy guards the first request.
        repeat (RESET_CYCLES)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all timers count down.
        write_up_mask('0);
        issue_request(REQ_READ,  3'd0, '0);          // fresh timer: zero, stopped
        issue_request(REQ_TICK,  3'd7, CNT_MAX);     // tick with nothing running
        issue_request(REQ_SET,   3'd0, CNT_MAX);
        issue_request(REQ_START, 3'd0, '0);
        issue_request(REQ_START, 3'd0, '0);          // start while running
        issue_request(REQ_TICK,  3'd0, '0);          // count down from the top
        issue_request(REQ_SET,   3'd0, CNT_MAX);     // set while running
        issue_request(REQ_STOP,  3'd0, '0);
        issue_request(REQ_STOP,  3'd0, '0);          // stop while stopped
        issue_request(REQ_TICK,  3'd0, '0);          // stopped timer holds
        issue_request(REQ_START, 3'd1, '0);
        issue_request(REQ_TICK,  3'd1, '0);          // down counter holds at zero
        for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++)
            issue_request(REQ_W'(c), 3'd1, CNT_MAX); // spare codes act as reads
        issue_request(REQ_SET,   3'd7, CNT_W'(1));
        issue_request(REQ_START, 3'd7, '0);
        issue_request(REQ_TICK,  3'd7, '0);          // reach zero

        // Directed: all timers count up.
        write_up_mask('1);
        issue_request(REQ_SET,   3'd2, CNT_MAX - 1'b1);
        issue_request(REQ_START, 3'd2, '0);
        issue_request(REQ_TICK,  3'd2, '0);          // reach the top
        issue_request(REQ_TICK,  3'd2, '0);          // up counter holds at the top
        issue_request(REQ_TICK,  3'd1, '0);          // timer 1 keeps counting up
        issue_request(REQ_READ,  3'd0, '0);

        // Random phases, each under its own direction mask; extremes first.
        // Run the last phase with no gaps at full request rate.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       phase_mask = '0;
                1:       phase_mask = '1;
                default: phase_mask = MASK_W'($urandom());
            endcase
            gaps_on = (phase != NUM_PHASES - 1);
            write_up_mask(phase_mask);
            repeat (PHASE_REQUESTS)
                issue_random_request();
        end

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("tb_software_timer_bank: PASS");
        else
            $display("tb_software_timer_bank: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/stb_pkg.sv
src/stb_timer_cell.sv
src/stb_result_sel.sv
src/software_timer_bank.sv
src/stb_checker.sv
dv/stb_timer_checker.sv
dv/tb_software_timer_bank.sv
